// ===== rtl/gwt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwt_pkg
// shared types, result kind codes and helper functions of the word tokenizer
// ----------------------------------------------------------------------------
package gwt_pkg;

   localparam logic [7:0] MAX_WORD_BYTES = 8'd62;
   localparam logic [7:0] LEAD_BYTE      = 8'hC3;
   localparam int         MAX_RESULTS    = 4;

   localparam logic [2:0] KIND_WORD_BYTE = 3'd0;
   localparam logic [2:0] KIND_WORD_END  = 3'd1;
   localparam logic [2:0] KIND_SPECIAL   = 3'd2;
   localparam logic [2:0] KIND_OVERLEN   = 3'd3;
   localparam logic [2:0] KIND_LINE_END  = 3'd4;

   typedef struct packed {
      logic [7:0] token_byte;
      logic [2:0] kind;
   } result_type;

   // up to four results of one beat, count in 0..4
   typedef struct packed {
      result_type [MAX_RESULTS-1:0] item;
      logic [2:0]                   count;
   } result_list_type;

   typedef struct packed {
      logic       word_open;
      logic [7:0] word_bytes;
      logic       lead_pending;
   } tok_state_type;

   function automatic logic is_letter(input logic [7:0] b);
      return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
   endfunction

   function automatic logic is_umlaut_tail(input logic [7:0] b);
      return (b == 8'h84) || (b == 8'h96) || (b == 8'h9C) || (b == 8'hA4) ||
             (b == 8'hB6) || (b == 8'hBC) || (b == 8'h9F);
   endfunction

   // saturating byte count
   function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [1:0] n);
      logic [8:0] sum;
      sum = {1'b0, a} + {7'd0, n};
      return sum[8] ? 8'hFF : sum[7:0];
   endfunction

   // append one result, extra results beyond four are dropped
   function automatic result_list_type put_result(input result_list_type l,
                                                  input logic [7:0]      b,
                                                  input logic [2:0]      k);
      result_list_type r;
      r = l;
      if (r.count < 3'd4) begin
         r.item[r.count[1:0]].token_byte = b;
         r.item[r.count[1:0]].kind       = k;
         r.count                         = r.count + 3'd1;
      end
      return r;
   endfunction

endpackage

// ===== rtl/gwt_token_logic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwt_token_logic
// single-pass classification of one byte into its list of results
// ----------------------------------------------------------------------------
module gwt_token_logic
   import gwt_pkg::*;
(
   input  logic [7:0]      data_byte,
   input  logic            byte_valid,
   input  logic            line_end,
   input  tok_state_type   state_i,
   output tok_state_type   state_o,
   output result_list_type list_o
);

   always_comb begin
      tok_state_type   st;
      result_list_type lst;
      logic            fresh;
      st    = state_i;
      lst   = '0;
      fresh = 1'b0;

      if (byte_valid) begin
         if (st.lead_pending) begin
            st.lead_pending = 1'b0;
            if (is_umlaut_tail(data_byte)) begin
               if (st.word_open && (st.word_bytes >= MAX_WORD_BYTES)) begin
                  lst           = put_result(lst, 8'h00, KIND_OVERLEN);
                  st.word_bytes = 8'd0;
               end
               st.word_open  = 1'b1;
               lst           = put_result(lst, LEAD_BYTE, KIND_WORD_BYTE);
               lst           = put_result(lst, data_byte, KIND_WORD_BYTE);
               st.word_bytes = sat_add(st.word_bytes, 2'd2);
            end else begin
               if (st.word_open) begin
                  lst = put_result(lst, 8'h00, (st.word_bytes >= MAX_WORD_BYTES) ?
                                               KIND_OVERLEN : KIND_WORD_END);
                  st.word_open  = 1'b0;
                  st.word_bytes = 8'd0;
               end
               lst   = put_result(lst, LEAD_BYTE, KIND_SPECIAL);
               fresh = 1'b1;
            end
         end else begin
            fresh = 1'b1;
         end

         if (fresh) begin
            if (is_letter(data_byte)) begin
               if (st.word_open && (st.word_bytes >= MAX_WORD_BYTES)) begin
                  lst           = put_result(lst, 8'h00, KIND_OVERLEN);
                  st.word_bytes = 8'd0;
               end
               st.word_open  = 1'b1;
               lst           = put_result(lst, data_byte, KIND_WORD_BYTE);
               st.word_bytes = sat_add(st.word_bytes, 2'd1);
            end else if (data_byte == LEAD_BYTE) begin
               st.lead_pending = 1'b1;
            end else begin
               if (st.word_open) begin
                  lst = put_result(lst, 8'h00, (st.word_bytes >= MAX_WORD_BYTES) ?
                                               KIND_OVERLEN : KIND_WORD_END);
                  st.word_open  = 1'b0;
                  st.word_bytes = 8'd0;
               end
               lst = put_result(lst, data_byte, KIND_SPECIAL);
            end
         end
      end

      if (line_end) begin
         if (st.lead_pending) begin
            if (st.word_open) begin
               lst = put_result(lst, 8'h00, (st.word_bytes >= MAX_WORD_BYTES) ?
                                            KIND_OVERLEN : KIND_WORD_END);
               st.word_open  = 1'b0;
               st.word_bytes = 8'd0;
            end
            lst = put_result(lst, LEAD_BYTE, KIND_SPECIAL);
         end
         // crowded line end: the line-end marker also closes the word
         if (st.word_open && (lst.count < 3'd3)) begin
            lst = put_result(lst, 8'h00, (st.word_bytes >= MAX_WORD_BYTES) ?
                                         KIND_OVERLEN : KIND_WORD_END);
         end
         lst = put_result(lst, 8'h00, KIND_LINE_END);
         st  = '0;
      end

      state_o = st;
      list_o  = lst;
   end

endmodule

// ===== rtl/gwt_result_buffer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwt_result_buffer
// holds the results of one beat and hands them out one per cycle while out_ready_i is high
// ----------------------------------------------------------------------------
module gwt_result_buffer
   import gwt_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            load_i,
   input  result_list_type list_i,
   output logic            free_o,
   output logic            out_valid_o,
   input  logic            out_ready_i,
   output result_type      out_result_o,
   output logic            out_last_o
);

   result_type [MAX_RESULTS-1:0] item_ff;
   result_type [MAX_RESULTS-1:0] item_in;
   logic [2:0]                   count_ff, count_in;
   logic [1:0]                   index_ff, index_in;
   logic                         final_beat;
   logic                         take;

   assign out_valid_o  = (count_ff != 3'd0);
   assign final_beat   = ({1'b0, index_ff} == (count_ff - 3'd1));
   assign take         = out_valid_o && out_ready_i;
   assign free_o       = !out_valid_o || (take && final_beat);
   assign out_result_o = item_ff[index_ff];
   assign out_last_o   = final_beat;

   always_comb begin
      item_in  = item_ff;
      count_in = count_ff;
      index_in = index_ff;
      if (take) begin
         if (final_beat) begin
            count_in = 3'd0;
         end else begin
            index_in = index_ff + 2'd1;
         end
      end
      if (load_i && free_o) begin
         item_in  = list_i.item;
         count_in = list_i.count;
         index_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (reset) begin
         count_ff <= 3'd0;
         index_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
         index_ff <= index_in;
      end
   end

endmodule

// ===== rtl/german_word_tokenizer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// german_word_tokenizer_unit
// splits a stream of line bytes into words, special characters and markers
// ----------------------------------------------------------------------------
// usage
//  - req channel: one beat per line byte; tdata is the byte, tuser flags a
//    real byte (clear for an empty line end), tlast ends the line
//  - rsp channel: one beat per result; tdata is the token byte (zero for
//    markers), tuser the kind, tlast marks the final result of a req beat
//  - a req beat is registered, classified in one pass of combinational logic
//    and its results (none to four) are loaded into the result buffer
//  - throughput: one req beat per cycle while each gives at most one result
//    and rsp_tready is high; a beat with n results holds the buffer until
//    all are taken; the buffer draining one result per cycle sets the rate
//  - beats that give no result pass through without using the buffer
//  - word state (open word, byte count, held 0xC3 lead byte) changes when the
//    input register hands its beat to the buffer, so it follows beat order
//  - rsp stall: the buffer holds, the input register then fills and req_tready
//    drops until the buffer frees up
//  - reset (synchronous, active high) empties both stages and clears the
//    word state
// ----------------------------------------------------------------------------
module german_word_tokenizer_unit
   import gwt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   // request side
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic [0:0] req_tuser,   // [0] byte_valid
   input  logic       req_tlast,   // line_end
   // result side
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] token_byte
   output logic [2:0] rsp_tuser,   // [2:0] kind
   output logic       rsp_tlast    // last result of the request beat
);

   // input register
   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_byte_ff, in_byte_in;
   logic            in_bvalid_ff, in_bvalid_in;
   logic            in_end_ff, in_end_in;

   // word state
   tok_state_type   state_ff, state_in;

   tok_state_type   next_state;
   result_list_type list;
   result_type      out_result;
   logic            buf_free;
   logic            advance;
   logic            req_take;

   // the input register moves on whenever the buffer can take its results
   assign advance    = in_valid_ff && buf_free;
   assign req_tready = !in_valid_ff || buf_free;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      in_bvalid_in = in_bvalid_ff;
      in_end_in    = in_end_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_take) begin
         in_valid_in  = 1'b1;
         in_byte_in   = req_tdata;
         in_bvalid_in = req_tuser[0];
         in_end_in    = req_tlast;
      end
      state_in = advance ? next_state : state_ff;
   end

   always_ff @(posedge clock) begin
      in_byte_ff   <= in_byte_in;
      in_bvalid_ff <= in_bvalid_in;
      in_end_ff    <= in_end_in;
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
      end
   end

   // classification of the registered beat
   gwt_token_logic u_logic (
      .data_byte  (in_byte_ff),
      .byte_valid (in_bvalid_ff),
      .line_end   (in_end_ff),
      .state_i    (state_ff),
      .state_o    (next_state),
      .list_o     (list)
   );

   // result register, drained one beat per cycle while rsp_tready is high
   gwt_result_buffer u_buffer (
      .clock        (clock),
      .reset        (reset),
      .load_i       (advance && (list.count != 3'd0)),
      .list_i       (list),
      .free_o       (buf_free),
      .out_valid_o  (rsp_tvalid),
      .out_ready_i  (rsp_tready),
      .out_result_o (out_result),
      .out_last_o   (rsp_tlast)
   );

   assign rsp_tdata = out_result.token_byte;
   assign rsp_tuser = out_result.kind;

endmodule
